[hw/rtl/nees_pkg.sv]
package nees_pkg;

  localparam int unsigned MW = 40;  // intermediate width (signed, clamp 2^39-1)
  localparam int unsigned VW = 40;
  localparam int unsigned SW = 48;
  localparam int unsigned CW = 32;

  localparam logic [MW-1:0] MID_LIMIT = 40'h7F_FFFF_FFFF;
  localparam logic [VW-1:0] VAL_LIMIT = 40'hFF_FFFF_FFFF;

  // Datapath operation codes
  localparam logic [2:0] OP_NONE = 3'd0;
  localparam logic [2:0] OP_LOAD = 3'd1;
  localparam logic [2:0] OP_DIV  = 3'd2;
  localparam logic [2:0] OP_MSUB = 3'd3;
  localparam logic [2:0] OP_TERM = 3'd4;
  localparam logic [2:0] OP_ACC  = 3'd5;

  // Register file addresses
  localparam logic [3:0] R_E0  = 4'd0;
  localparam logic [3:0] R_E1  = 4'd1;
  localparam logic [3:0] R_E2  = 4'd2;
  localparam logic [3:0] R_A00 = 4'd3;
  localparam logic [3:0] R_A10 = 4'd4;
  localparam logic [3:0] R_A20 = 4'd5;
  localparam logic [3:0] R_A11 = 4'd6;
  localparam logic [3:0] R_A21 = 4'd7;
  localparam logic [3:0] R_A22 = 4'd8;
  localparam logic [3:0] R_L10 = 4'd9;
  localparam logic [3:0] R_L20 = 4'd10;
  localparam logic [3:0] R_L21 = 4'd11;
  localparam logic [3:0] R_Z   = 4'd12;
  localparam logic [3:0] R_ZERO = 4'd13;

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] ra;   // dividend / minuend / term y
    logic [3:0] rb;   // divisor / product operand a
    logic [3:0] rc;   // product operand b
    logic [3:0] rd;   // destination
    logic       chk;  // pivot test on rb before divide
  } nees_cmd_t;

  typedef struct packed {
    logic busy;
    logic piv_ok;
  } nees_sts_t;

endpackage

[hw/rtl/nees_div.sv]
// Radix-2 restoring divider on magnitudes, one quotient bit a cycle.
module nees_div #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [nees_pkg::MW-1:0] num_mag,
  input  logic [nees_pkg::MW-1:0] den_mag,
  output logic                  done,
  output logic [nees_pkg::MW+FRAC_BITS-1:0] quo
);
  localparam int unsigned NW = nees_pkg::MW + FRAC_BITS;
  localparam int unsigned CNTW = $clog2(NW + 1);

  logic [NW-1:0]   q_r, q_nxt;
  logic [nees_pkg::MW:0] rem_r, rem_nxt;
  logic [nees_pkg::MW-1:0] den_r, den_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            run_r, run_nxt, done_r, done_nxt;
  logic [nees_pkg::MW:0] trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; den_nxt = den_r; cnt_nxt = cnt_r;
    run_nxt = run_r; done_nxt = 1'b0;
    trial = '0;
    if (start) begin
      q_nxt = {num_mag, {FRAC_BITS{1'b0}}};
      rem_nxt = '0; den_nxt = den_mag;
      cnt_nxt = CNTW'(NW); run_nxt = 1'b1;
    end else if (run_r) begin
      trial = {rem_r[nees_pkg::MW-1:0], q_r[NW-1]};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNTW'(1)) begin
        run_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      run_r <= run_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule

[hw/rtl/nees_dp.sv]
// Datapath: register file, one shared multiplier and one shared divider.
module nees_dp #(
  parameter int unsigned NUM_GROUPS = 5,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  nees_pkg::nees_cmd_t  cmd,
  output nees_pkg::nees_sts_t  sts,
  input  logic [15:0]          tol,
  input  logic [2:0]           in_group,
  input  logic [287:0]         in_words,
  output logic [nees_pkg::VW-1:0] nees_value,
  output logic [nees_pkg::SW-1:0] group_total,
  output logic [nees_pkg::CW-1:0] sample_total,
  output logic                 pivot_dropped,
  output logic                 saturated
);
  localparam int unsigned MW = nees_pkg::MW;
  localparam int unsigned NW = MW + FRAC_BITS;
  localparam int unsigned GW = (NUM_GROUPS > 1) ? $clog2(NUM_GROUPS) : 1;

  logic signed [MW-1:0] rf_r [0:13];
  logic signed [MW+2:0] qacc_r;
  logic [2:0]  grp_r;
  logic        drop_r, sat_r;
  logic [nees_pkg::SW-1:0] sums_r [0:NUM_GROUPS-1];
  logic [nees_pkg::CW-1:0] cnt_r;
  logic [nees_pkg::VW-1:0] val_r;
  logic [nees_pkg::SW-1:0] tot_r;
  logic        div_busy_r, msub_ph_r;
  logic [MW-1:0] prod_r;     // registered product magnitude (clamped)
  logic        prod_neg_r;

  // Operand selection
  logic signed [MW-1:0] opa, opb, opc;
  assign opa = rf_r[cmd.ra];
  assign opb = rf_r[cmd.rb];
  assign opc = rf_r[cmd.rc];

  function automatic logic [MW-1:0] magf(input logic signed [MW-1:0] v);
    return v[MW-1] ? MW'(-v) : MW'(v);
  endfunction

  // Pivot test on the divisor
  logic [MW-1:0] bmag;
  assign bmag = magf(opb);
  assign sts.piv_ok = (bmag != '0) && (bmag >= MW'(tol));

  // Divider
  logic div_start, div_done;
  logic [NW-1:0] div_q;
  assign div_start = (cmd.op == nees_pkg::OP_DIV) && !div_busy_r && sts.piv_ok;
  nees_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk, .rst_n, .start(div_start), .num_mag(magf(opa)), .den_mag(bmag),
    .done(div_done), .quo(div_q)
  );

  // Multiplier on magnitudes: 40x40 split into 20-bit halves, four partial
  // products summed on successive cycles, then a write-back step.
  logic [1:0]  mph_r;
  logic [2*MW-1:0] macc_r;
  logic [MW/2-1:0] mx, my;
  logic [MW-1:0]   pp;
  logic [MW-1:0]   mam, mbm;
  logic        mul_op, mul_neg;
  assign mul_op = (cmd.op == nees_pkg::OP_MSUB) || (cmd.op == nees_pkg::OP_TERM);
  assign mam = (cmd.op == nees_pkg::OP_TERM) ? magf(opa) : magf(opb);
  assign mbm = (cmd.op == nees_pkg::OP_TERM) ? magf(rf_r[nees_pkg::R_Z]) : magf(opc);
  assign mul_neg = (cmd.op == nees_pkg::OP_TERM) ? (opa[MW-1] ^ rf_r[nees_pkg::R_Z][MW-1])
                                                 : (opb[MW-1] ^ opc[MW-1]);
  assign mx = mph_r[0] ? mam[MW-1:MW/2] : mam[MW/2-1:0];
  assign my = mph_r[1] ? mbm[MW-1:MW/2] : mbm[MW/2-1:0];
  assign pp = mx * my;

  logic [2*MW-1:0] pp_sh, full;
  always_comb begin
    case (mph_r)
      2'd0:    pp_sh = (2*MW)'(pp);
      2'd3:    pp_sh = {pp, {MW{1'b0}}};
      default: pp_sh = (2*MW)'({pp, {(MW/2){1'b0}}});
    endcase
  end
  assign full = macc_r + pp_sh;

  // Scaled and clamped product
  logic [2*MW-1:0] shp;
  logic [MW-1:0]   plim;
  logic            pclamp;
  logic [MW-1:0]   pres;
  assign shp = full >> FRAC_BITS;
  assign plim = (cmd.op == nees_pkg::OP_TERM) ? nees_pkg::VAL_LIMIT : nees_pkg::MID_LIMIT;
  assign pclamp = (shp[2*MW-1:MW] != '0) || (shp[MW-1:0] > plim);
  assign pres = pclamp ? plim : shp[MW-1:0];

  // Subtraction and clamp for MSUB
  logic signed [MW+1:0] diff;
  logic signed [MW+1:0] pmax;
  logic signed [MW-1:0] dclamp;
  logic        dsat;
  assign pmax = (MW+2)'(nees_pkg::MID_LIMIT);
  assign diff = (MW+2)'(opa) - (prod_neg_r ? -(MW+2)'($signed({1'b0, prod_r}))
                                            :  (MW+2)'($signed({1'b0, prod_r})));
  always_comb begin
    dsat = 1'b0;
    dclamp = MW'(diff);
    if (diff > pmax) begin
      dclamp = MW'(pmax); dsat = 1'b1;
    end else if (diff < -pmax) begin
      dclamp = MW'(-pmax); dsat = 1'b1;
    end
  end

  // Divider result, clamped to the intermediate limit
  logic [MW-1:0] dq;
  logic          dqsat;
  assign dqsat = (div_q[NW-1:MW] != '0) || (div_q[MW-1:0] > nees_pkg::MID_LIMIT);
  assign dq = dqsat ? nees_pkg::MID_LIMIT : div_q[MW-1:0];

  logic div_neg_r;
  logic [GW-1:0] gi;
  logic          gvalid;
  logic [nees_pkg::SW:0] tsum;
  logic [nees_pkg::VW-1:0] vq;
  logic          vsat;
  assign gi = GW'(grp_r);
  assign gvalid = {29'd0, grp_r} < NUM_GROUPS;
  always_comb begin
    vsat = 1'b0;
    if (qacc_r[MW+2]) begin
      vq = '0; vsat = 1'b1;
    end else if (qacc_r[MW+1:MW] != '0) begin
      vq = nees_pkg::VAL_LIMIT; vsat = 1'b1;
    end else begin
      vq = qacc_r[MW-1:0];
    end
  end
  assign tsum = {1'b0, sums_r[gi]} + {{(nees_pkg::SW-nees_pkg::VW+1){1'b0}}, vq};

  // Busy until the divide finishes or the product is written back
  logic busy_c;
  always_comb begin
    busy_c = 1'b0;
    if (cmd.op == nees_pkg::OP_DIV && sts.piv_ok && !div_done) busy_c = 1'b1;
    if (mul_op && !msub_ph_r) busy_c = 1'b1;
  end
  assign sts.busy = busy_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0; mph_r <= '0; msub_ph_r <= 1'b0;
      cnt_r <= '0;
      for (int i = 0; i < NUM_GROUPS; i++) sums_r[i] <= '0;
    end else begin
      // Divider control
      if (div_start) begin
        div_busy_r <= 1'b1;
        div_neg_r <= opa[MW-1] ^ opb[MW-1];
      end
      if (div_done) div_busy_r <= 1'b0;
      // Multiplier sequencing; fourth step writes the product register
      if (mul_op && !msub_ph_r) begin
        if (mph_r == 2'd0) macc_r <= (2*MW)'(pp);
        else macc_r <= full;
        mph_r <= mph_r + 1'b1;
        if (mph_r == 2'd3) begin
          prod_r <= pres; prod_neg_r <= mul_neg;
          if (pclamp) sat_r <= 1'b1;
          msub_ph_r <= 1'b1;
        end
      end else if (msub_ph_r) begin
        msub_ph_r <= 1'b0; mph_r <= '0;
        if (cmd.op == nees_pkg::OP_MSUB) begin
          rf_r[cmd.rd] <= dclamp;
          if (dsat) sat_r <= 1'b1;
        end else begin
          qacc_r <= qacc_r + (prod_neg_r ? -(MW+3)'({1'b0, prod_r})
                                         :  (MW+3)'({1'b0, prod_r}));
        end
      end
      // Division write-back, or zero on a dropped pivot
      if (cmd.op == nees_pkg::OP_DIV && !div_busy_r && !sts.piv_ok) begin
        rf_r[cmd.rd] <= '0; drop_r <= 1'b1;
      end
      if (div_done) begin
        rf_r[cmd.rd] <= div_neg_r ? -$signed(dq) : $signed(dq);
        if (dqsat) sat_r <= 1'b1;
      end
      // Accumulate and publish the result
      if (cmd.op == nees_pkg::OP_ACC) begin
        val_r <= vq;
        if (vsat || (gvalid && tsum[nees_pkg::SW])) sat_r <= 1'b1;
        if (!gvalid) begin
          tot_r <= '0;
        end else if (tsum[nees_pkg::SW]) begin
          sums_r[gi] <= '1; tot_r <= '1;
        end else begin
          sums_r[gi] <= tsum[nees_pkg::SW-1:0];
          tot_r <= tsum[nees_pkg::SW-1:0];
        end
        if (gvalid && {29'd0, grp_r} == NUM_GROUPS - 1 && cnt_r != '1)
          cnt_r <= cnt_r + 1'b1;
      end
    end
    if (cmd.op == nees_pkg::OP_LOAD) begin
      for (int i = 0; i < 9; i++)
        rf_r[i] <= MW'($signed(in_words[32*i +: 32]));
      rf_r[nees_pkg::R_ZERO] <= '0;
      grp_r <= in_group; drop_r <= 1'b0; sat_r <= 1'b0; qacc_r <= '0;
    end
  end

  assign nees_value = val_r;
  assign group_total = tot_r;
  assign sample_total = cnt_r;
  assign pivot_dropped = drop_r;
  assign saturated = sat_r;
endmodule

[hw/rtl/nees_ctrl.sv]
// Sequencer: steps through the LDLT program, one command at a time.
module nees_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic                out_free,
  output logic                in_ready,
  output logic                out_load,
  output nees_pkg::nees_cmd_t cmd,
  input  nees_pkg::nees_sts_t sts
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_WAIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [4:0] pc_r, pc_nxt;
  localparam logic [4:0] LAST = 5'd17;

  function automatic nees_pkg::nees_cmd_t prog(input logic [4:0] pc);
    nees_pkg::nees_cmd_t c;
    c = '{op: nees_pkg::OP_NONE, ra: '0, rb: '0, rc: '0, rd: '0, chk: 1'b0};
    case (pc)
      5'd0:  c = '{nees_pkg::OP_LOAD, 4'd0, 4'd0, 4'd0, 4'd0, 1'b0};
      5'd1:  c = '{nees_pkg::OP_DIV,  nees_pkg::R_A10, nees_pkg::R_A00, 4'd0, nees_pkg::R_L10, 1'b1};
      5'd2:  c = '{nees_pkg::OP_DIV,  nees_pkg::R_A20, nees_pkg::R_A00, 4'd0, nees_pkg::R_L20, 1'b1};
      5'd3:  c = '{nees_pkg::OP_MSUB, nees_pkg::R_A11, nees_pkg::R_L10, nees_pkg::R_A10, nees_pkg::R_A11, 1'b0};
      5'd4:  c = '{nees_pkg::OP_MSUB, nees_pkg::R_A21, nees_pkg::R_L20, nees_pkg::R_A10, nees_pkg::R_A21, 1'b0};
      5'd5:  c = '{nees_pkg::OP_DIV,  nees_pkg::R_A21, nees_pkg::R_A11, 4'd0, nees_pkg::R_L21, 1'b1};
      5'd6:  c = '{nees_pkg::OP_MSUB, nees_pkg::R_A22, nees_pkg::R_L20, nees_pkg::R_A20, nees_pkg::R_A22, 1'b0};
      5'd7:  c = '{nees_pkg::OP_MSUB, nees_pkg::R_A22, nees_pkg::R_L21, nees_pkg::R_A21, nees_pkg::R_A22, 1'b0};
      5'd8:  c = '{nees_pkg::OP_MSUB, nees_pkg::R_E1, nees_pkg::R_L10, nees_pkg::R_E0, nees_pkg::R_E1, 1'b0};
      5'd9:  c = '{nees_pkg::OP_MSUB, nees_pkg::R_E2, nees_pkg::R_L20, nees_pkg::R_E0, nees_pkg::R_E2, 1'b0};
      5'd10: c = '{nees_pkg::OP_MSUB, nees_pkg::R_E2, nees_pkg::R_L21, nees_pkg::R_E1, nees_pkg::R_E2, 1'b0};
      5'd11: c = '{nees_pkg::OP_DIV,  nees_pkg::R_E0, nees_pkg::R_A00, 4'd0, nees_pkg::R_Z, 1'b1};
      5'd12: c = '{nees_pkg::OP_TERM, nees_pkg::R_E0, 4'd0, 4'd0, 4'd0, 1'b0};
      5'd13: c = '{nees_pkg::OP_DIV,  nees_pkg::R_E1, nees_pkg::R_A11, 4'd0, nees_pkg::R_Z, 1'b1};
      5'd14: c = '{nees_pkg::OP_TERM, nees_pkg::R_E1, 4'd0, 4'd0, 4'd0, 1'b0};
      5'd15: c = '{nees_pkg::OP_DIV,  nees_pkg::R_E2, nees_pkg::R_A22, 4'd0, nees_pkg::R_Z, 1'b1};
      5'd16: c = '{nees_pkg::OP_TERM, nees_pkg::R_E2, 4'd0, 4'd0, 4'd0, 1'b0};
      5'd17: c = '{nees_pkg::OP_ACC,  4'd0, 4'd0, 4'd0, 4'd0, 1'b0};
      default: c = '{nees_pkg::OP_NONE, 4'd0, 4'd0, 4'd0, 4'd0, 1'b0};
    endcase
    return c;
  endfunction

  logic running;
  assign running = (state_r == S_RUN);
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    cmd = running ? prog(pc_r) : prog(5'd31);
    if (state_r == S_IDLE && in_fire) cmd = prog(5'd0);
  end

  always_comb begin
    state_nxt = state_r; pc_nxt = pc_r; out_load = 1'b0;
    case (state_r)
      S_IDLE: if (in_fire) begin
        state_nxt = S_RUN; pc_nxt = 5'd1;
      end
      S_RUN: if (!sts.busy) begin
        if (pc_r == LAST) state_nxt = S_WAIT;
        else pc_nxt = pc_r + 1'b1;
      end
      S_WAIT: if (out_free) begin
        out_load = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; pc_r <= '0;
    end else begin
      state_r <= state_nxt; pc_r <= pc_nxt;
    end
  end
endmodule

[hw/rtl/block_nees_accumulator.sv]
// Channel | Dir | tdata fields (low bit first)                      | tuser
// in_     | in  | error_x..z, cov_00,10,20,11,21,22 (32b each, 288b) | group_index
// out_    | out | nees_value 40, group_total 48, sample_total 32     | pivot_dropped, saturated
// cfg_    | in  | pivot_tolerance 16b write-only                     | -
// One request at a time: six divides on the shared bit-serial divider,
// ten products on the shared multiplier, plus load, accumulate and handoff;
// the next request is accepted only after the result is handed off.
// A zero pivot or one below tolerance skips its divide and writes zero.
// Reset (rst_n low, synchronous) clears the group sums, counter and tolerance=1.
// A held result stalls the sequencer before handoff; input waits meanwhile.
module block_nees_accumulator #(
  parameter int unsigned NUM_GROUPS = 5,
  parameter int unsigned FRAC_BITS  = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [287:0] in_tdata,   // error_x, error_y, error_z, cov_00..cov_22
  input  logic [2:0]   in_tuser,   // group_index
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // nees_value, group_total, sample_total
  output logic [1:0]   out_tuser,  // pivot_dropped, saturated
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata   // pivot_tolerance
);
  logic [15:0] tol_r;
  logic        vld_r;
  logic [119:0] od_r;
  logic [1:0]   ou_r;
  logic        out_load, ready_c;
  nees_pkg::nees_cmd_t cmd;
  nees_pkg::nees_sts_t sts;
  logic [39:0] nv; logic [47:0] gt; logic [31:0] st; logic pd, sa;

  nees_ctrl u_ctrl (
    .clk, .rst_n, .in_fire(in_tvalid && ready_c), .out_free(!vld_r || out_tready),
    .in_ready(ready_c), .out_load, .cmd, .sts
  );

  nees_dp #(.NUM_GROUPS(NUM_GROUPS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .tol(tol_r), .in_group(in_tuser), .in_words(in_tdata),
    .nees_value(nv), .group_total(gt), .sample_total(st),
    .pivot_dropped(pd), .saturated(sa)
  );

  // Configuration register and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= 16'd1; vld_r <= 1'b0;
    end else begin
      if (cfg_we) tol_r <= cfg_wdata;
      if (out_load) vld_r <= 1'b1;
      else if (out_tready) vld_r <= 1'b0;
    end
    if (out_load) begin
      od_r <= {st, gt, nv}; ou_r <= {sa, pd};
    end
  end

  assign in_tready = ready_c;
  assign out_tvalid = vld_r;
  assign out_tdata = od_r;
  assign out_tuser = ou_r;

`ifndef SYNTHESIS
  a_no_load_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!vld_r || out_tready)) else $error("result overwritten");
  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result changed while stalled");
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready) else $error("second accept");
`endif
endmodule
